// ----- rtl/koc_pkg.sv -----
// Package for the key occurrence counter: field widths, defaults,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package koc_pkg;

    localparam int FIRST_W          = 12;
    localparam int SECOND_W         = 10;
    localparam int KEY_W            = 22;
    localparam int OCC_W            = 16;
    localparam int KEY_MULT         = 1000;
    localparam int ENTRIES_DEF      = 256;
    localparam int COUNT_BITS_DEF   = 16;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } t_state;

    typedef struct packed {
        logic load;      // capture key, restart the scan
        logic scan;      // read the next stored entry
        logic hit_upd;   // write back the raised count, post result
        logic miss_upd;  // append the key or flag a full table, post result
    } t_cmd;

    typedef struct packed {
        logic hit;       // entry read last cycle holds the key
        logic scan_end;  // all stored entries read and compared
    } t_sts;

endpackage

`default_nettype wire

// ----- rtl/koc_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module koc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/koc_ctrl.sv -----
// Controller for the key occurrence counter: walks each item through load and scan.
// Depends on koc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module koc_ctrl
    import koc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  t_sts      i_sts,
    output t_cmd      o_cmd,
    output logic      o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_sts.hit) begin
                    o_cmd.hit_upd = 1'b1;
                    n_state       = ST_IDLE;
                end else if (i_sts.scan_end) begin
                    o_cmd.miss_upd = 1'b1;
                    n_state        = ST_IDLE;
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

`default_nettype wire

// ----- rtl/koc_dp.sv -----
// Datapath for the key occurrence counter: key forming, table memory,
// scan index, fill level, count update and result registers.
// Depends on koc_pkg and koc_ram.
`timescale 1ns / 1ps
`default_nettype none

module koc_dp
    import koc_pkg::*;
#(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic [FIRST_W-1:0]  i_first_value,
    input  wire logic [SECOND_W-1:0] i_second_value,
    input  t_cmd                     i_cmd,
    output t_sts                     o_sts,
    output logic                     o_valid,
    output logic [KEY_W-1:0]         o_combined_key,
    output logic [OCC_W-1:0]         o_occurrence,
    output logic                     o_table_full
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int RAM_W = KEY_W + COUNT_BITS;

    logic [KEY_W-1:0]      w_key;
    logic [RAM_W-1:0]      w_rdata;
    logic [KEY_W-1:0]      w_rd_key;
    logic [COUNT_BITS-1:0] w_rd_cnt;
    logic [COUNT_BITS-1:0] w_cnt_inc;
    logic [COUNT_BITS-1:0] w_cnt_one;
    logic [OCC_W+COUNT_BITS-1:0] w_occ_ext;
    logic                  w_issue;
    logic                  w_room;
    logic                  w_we;
    logic [IDX_W-1:0]      w_waddr;
    logic [RAM_W-1:0]      w_wdata;

    logic [KEY_W-1:0]      r_key;
    logic [CNT_W-1:0]      r_idx;
    logic [CNT_W-1:0]      r_fill;
    logic                  r_pend;
    logic [IDX_W-1:0]      r_pend_idx;
    logic                  r_valid;
    logic [KEY_W-1:0]      r_out_key;
    logic [OCC_W-1:0]      r_occ;
    logic                  r_full;

    assign w_key = KEY_W'(KEY_W'(i_first_value) * KEY_W'(KEY_MULT))
                 + KEY_W'(i_second_value);

    assign w_rd_key  = w_rdata[RAM_W-1:COUNT_BITS];
    assign w_rd_cnt  = w_rdata[COUNT_BITS-1:0];
    // saturate at the all-ones count
    assign w_cnt_inc = (&w_rd_cnt) ? w_rd_cnt : w_rd_cnt + 1'b1;
    assign w_cnt_one = COUNT_BITS'(1);
    assign w_occ_ext = {{OCC_W{1'b0}}, w_cnt_inc};

    assign w_issue = i_cmd.scan && (r_idx < r_fill);
    assign w_room  = (r_fill != CNT_W'(ENTRIES));

    assign o_sts.hit      = r_pend && (w_rd_key == r_key);
    assign o_sts.scan_end = !r_pend && (r_idx >= r_fill);

    assign w_we    = i_cmd.hit_upd || (i_cmd.miss_upd && w_room);
    assign w_waddr = i_cmd.hit_upd ? r_pend_idx : r_fill[IDX_W-1:0];
    assign w_wdata = {r_key, (i_cmd.hit_upd ? w_cnt_inc : w_cnt_one)};

    koc_ram #(
        .WIDTH (RAM_W),
        .DEPTH (ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_fill  <= '0;
            r_pend  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.hit_upd || i_cmd.miss_upd;
            if (i_cmd.load) begin
                r_idx  <= '0;
                r_pend <= 1'b0;
            end else if (i_cmd.scan) begin
                r_pend <= w_issue;
                if (w_issue) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            if (i_cmd.miss_upd && w_room) begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key <= w_key;
        end
        if (i_cmd.scan) begin
            r_pend_idx <= r_idx[IDX_W-1:0];
        end
        if (i_cmd.hit_upd) begin
            r_out_key <= r_key;
            r_occ     <= w_occ_ext[OCC_W-1:0];
            r_full    <= 1'b0;
        end else if (i_cmd.miss_upd) begin
            r_out_key <= r_key;
            r_occ     <= w_room ? OCC_W'(1) : '0;
            r_full    <= !w_room;
        end
    end

    assign o_valid        = r_valid;
    assign o_combined_key = r_out_key;
    assign o_occurrence   = r_occ;
    assign o_table_full   = r_full;

endmodule

`default_nettype wire

// ----- rtl/key_occurrence_counter.sv -----
// A key found at entry j is posted after entries 0 to j have been read and compared; a new
// key after every stored entry, at once on an empty table. busy drops in the strobe cycle,
// so the next start can be taken there. Throughput is set by the table memory's single
// read port, which scans one stored entry per cycle.
// Synchronous reset clears the fill level and the controller; table contents are kept,
// and entries above the fill level are never read. Results cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none

module key_occurrence_counter
    import koc_pkg::*;
#(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [FIRST_W-1:0]  i_first_value,
    input  wire logic [SECOND_W-1:0] i_second_value,
    output logic                     o_valid,
    output logic [KEY_W-1:0]         o_combined_key,
    output logic [OCC_W-1:0]         o_occurrence,
    output logic                     o_table_full
);

    t_cmd w_cmd;
    t_sts w_sts;

    koc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    koc_dp #(
        .ENTRIES    (ENTRIES),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_first_value  (i_first_value),
        .i_second_value (i_second_value),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .o_valid        (o_valid),
        .o_combined_key (o_combined_key),
        .o_occurrence   (o_occurrence),
        .o_table_full   (o_table_full)
    );

endmodule

`default_nettype wire

// ----- rtl/koc_checker.sv -----
// Port-level checker for the key occurrence counter, bound to the top level.
// Depends on koc_pkg and key_occurrence_counter.
`timescale 1ns / 1ps
`default_nettype none

module koc_checker
    import koc_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic               o_valid,
    input wire logic [OCC_W-1:0]   o_occurrence,
    input wire logic               o_table_full
);

    // a full-table result carries no count, any other result a nonzero one
    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_table_full == (o_occurrence == '0)))
        else $error("occurrence does not agree with table_full");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after start transfer");

    // busy drops exactly when a result is posted
    a_done_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("busy dropped without a result");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

endmodule

bind key_occurrence_counter koc_checker u_koc_checker (.*);

`default_nettype wire
